// ----- src/bmmq_pkg.sv -----
// Shared types, constants and float helpers for the block min/max quantizer.
`timescale 1ns / 1ps

package bmmq_pkg;

   localparam int DEFAULT_BLOCK_DEPTH = 64;
   localparam int CNT_W = 7;

   localparam logic [31:0] FLT_MAX_BITS    = 32'h7F7F_FFFF;
   localparam logic [31:0] FLT_LOWEST_BITS = 32'hFF7F_FFFF;
   localparam logic [31:0] FLT_INF_BITS    = 32'h7F80_0000;
   localparam logic [31:0] RANGE_EPS_BITS  = 32'h322B_CC77;  // 1e-8f
   localparam logic [7:0]  FLT_EXP_ALL_ONES = 8'hFF;

   localparam logic [15:0] LEVELS_NARROW = 16'h00FF;
   localparam logic [15:0] LEVELS_WIDE   = 16'hFFFF;

   // below this exponent the scaled code rounds to zero at either width
   localparam logic signed [9:0] NORM_EXP_MIN = -10'sd18;

   typedef struct packed {
      logic [31:0] sample;
      logic        has_sample;
      logic        block_end;
   } req_type;

   typedef struct packed {
      logic [15:0] code;
      logic        code_valid;
      logic [31:0] block_min;
      logic [31:0] block_max;
      logic        block_last;
      logic        overflowed;
   } rsp_type;

   // one closed block waiting for the back end
   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [31:0]      lo;
      logic [31:0]      hi;
      logic             cut;
      logic             bank;
   } desc_type;

   typedef struct packed {
      logic valid;
      logic full;
   } qstat_type;

   function automatic logic flt_finite(input logic [31:0] b);
      return b[30:23] != FLT_EXP_ALL_ONES;
   endfunction

endpackage

// ----- src/bmmq_front.sv -----
// Front end: accepts beats, tracks block min/max, writes the buffer, closes blocks.
`timescale 1ns / 1ps

module bmmq_front #(
   parameter int BLOCK_DEPTH = bmmq_pkg::DEFAULT_BLOCK_DEPTH,
   localparam int IDX_W = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  bmmq_pkg::req_type    req_data,
   output logic                 req_ready,
   input  bmmq_pkg::qstat_type  q_stat,
   output logic                 push,
   output bmmq_pkg::desc_type   push_desc,
   output logic                 wr_en,
   output logic [IDX_W:0]       wr_addr,
   output logic [31:0]          wr_data
);

   localparam int FILL_W = $clog2(BLOCK_DEPTH + 1);
   localparam logic [FILL_W-1:0] DEPTH_V = FILL_W'(BLOCK_DEPTH);

   logic [FILL_W-1:0] fill_ff, fill_in, fill_next;
   logic [31:0]       min_ff, min_in, min_next;
   logic [31:0]       max_ff, max_in, max_next;
   logic              any_ff, any_in, any_next;
   logic              bank_ff, bank_in;
   logic              accept, store, close;

   function automatic logic flt_less(input logic [31:0] a, input logic [31:0] b);
      if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return 1'b0;
      if (a[31] != b[31]) return a[31];
      if (!a[31]) return a[30:0] < b[30:0];
      return a[30:0] > b[30:0];
   endfunction

   assign req_ready = !q_stat.full;
   assign accept    = req_valid && req_ready;
   assign store     = req_data.has_sample;

   always_comb begin
      fill_next = fill_ff + FILL_W'(store);
      min_next  = min_ff;
      max_next  = max_ff;
      any_next  = any_ff;
      if (store && bmmq_pkg::flt_finite(req_data.sample)) begin
         if (flt_less(req_data.sample, min_ff)) min_next = req_data.sample;
         if (flt_less(max_ff, req_data.sample)) max_next = req_data.sample;
         any_next = 1'b1;
      end
      close = req_data.block_end || (fill_next == DEPTH_V);

      fill_in = fill_ff;
      min_in  = min_ff;
      max_in  = max_ff;
      any_in  = any_ff;
      bank_in = bank_ff;
      if (accept) begin
         if (close) begin
            fill_in = '0;
            min_in  = bmmq_pkg::FLT_MAX_BITS;
            max_in  = bmmq_pkg::FLT_LOWEST_BITS;
            any_in  = 1'b0;
            bank_in = !bank_ff;
         end else begin
            fill_in = fill_next;
            min_in  = min_next;
            max_in  = max_next;
            any_in  = any_next;
         end
      end
   end

   assign push            = accept && close;
   assign push_desc.count = bmmq_pkg::CNT_W'(fill_next);
   assign push_desc.lo    = any_next ? min_next : 32'd0;
   assign push_desc.hi    = any_next ? max_next : 32'd0;
   assign push_desc.cut   = !req_data.block_end;
   assign push_desc.bank  = bank_ff;

   assign wr_en   = accept && store;
   assign wr_addr = {bank_ff, fill_ff[IDX_W-1:0]};
   assign wr_data = req_data.sample;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         min_ff  <= bmmq_pkg::FLT_MAX_BITS;
         max_ff  <= bmmq_pkg::FLT_LOWEST_BITS;
         any_ff  <= 1'b0;
         bank_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         min_ff  <= min_in;
         max_ff  <= max_in;
         any_ff  <= any_in;
         bank_ff <= bank_in;
      end
   end

endmodule

// ----- src/bmmq_queue.sv -----
// Two-entry queue of closed-block descriptors between front and back end.
`timescale 1ns / 1ps

module bmmq_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  bmmq_pkg::desc_type   push_desc,
   input  logic                 pop,
   output bmmq_pkg::desc_type   head,
   output bmmq_pkg::qstat_type  q_stat
);

   bmmq_pkg::desc_type entry_ff [2];
   logic       rd_ptr_ff, rd_ptr_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      rd_ptr_in = rd_ptr_ff ^ pop;
      wr_ptr_in = wr_ptr_ff ^ push;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   assign head         = entry_ff[rd_ptr_ff];
   assign q_stat.valid = count_ff != 2'd0;
   assign q_stat.full  = count_ff == 2'd2;

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_desc;
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- src/bmmq_back.sv -----
// Back end: value buffer, float subtract, bit-serial divide, scaling and result register.
`timescale 1ns / 1ps

module bmmq_back #(
   parameter int BLOCK_DEPTH = bmmq_pkg::DEFAULT_BLOCK_DEPTH,
   localparam int IDX_W = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wide_codes,
   input  bmmq_pkg::qstat_type  q_stat,
   input  bmmq_pkg::desc_type   head,
   output logic                 pop,
   input  logic                 wr_en,
   input  logic [IDX_W:0]       wr_addr,
   input  logic [31:0]          wr_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output bmmq_pkg::rsp_type    rsp_data
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_SUB_ALIGN, ST_SUB_NORM, ST_SUB_ROUND, ST_READ, ST_LOAD,
      ST_DIV_PREP, ST_DIV_NORM, ST_DIV_STEP, ST_DIV_ROUND, ST_SCALE, ST_CODE, ST_EMIT
   } state_type;

   // ping-pong value buffer, one bank per block
   logic [31:0] mem [2**(IDX_W+1)];
   logic [31:0] rd_data_ff;

   state_type              state_ff, state_in;
   bmmq_pkg::desc_type     desc_ff, desc_in;
   logic [bmmq_pkg::CNT_W-1:0] idx_ff, idx_in;
   logic                   spread_ff, spread_in;
   logic [31:0]            den_ff, den_in;
   logic [31:0]            num_ff, num_in;
   logic [31:0]            opa_ff, opa_in, opb_ff, opb_in;
   logic                   for_den_ff, for_den_in;
   logic [27:0]            sum_ff, sum_in;
   logic [7:0]             sexp_ff, sexp_in;
   logic [23:0]            nm_ff, nm_in;
   logic [23:0]            dm_ff, dm_in;
   logic signed [9:0]      nexp_ff, nexp_in;
   logic signed [9:0]      kexp_ff, kexp_in;
   logic signed [9:0]      enorm_ff, enorm_in;
   logic [25:0]            rem_ff, rem_in;
   logic [54:0]            quo_ff, quo_in;
   logic [5:0]             step_ff, step_in;
   logic [53:0]            m54_ff, m54_in;
   logic [70:0]            r_ff, r_in;
   logic [15:0]            code_ff, code_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   bmmq_pkg::rsp_type      rsp_ff, rsp_in;

   // alignment of the subtract operands
   logic        swap, eff_sub;
   logic [31:0] big, sml;
   logic [7:0]  eb, es, dsh;
   logic [23:0] mb, ms;
   logic [26:0] ext, sml_sh, sml_al;
   logic        lost;
   logic [27:0] bigx, sum_al;

   assign swap    = opb_ff[30:0] > opa_ff[30:0];
   assign big     = swap ? opb_ff : opa_ff;
   assign sml     = swap ? opa_ff : opb_ff;
   assign eff_sub = opa_ff[31] == opb_ff[31];
   assign eb      = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
   assign es      = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
   assign mb      = {big[30:23] != 8'd0, big[22:0]};
   assign ms      = {sml[30:23] != 8'd0, sml[22:0]};
   assign dsh     = eb - es;
   assign ext     = {ms, 3'b000};
   assign sml_sh  = ext >> dsh;
   assign lost    = |(ext & ~({27{1'b1}} << dsh));
   assign sml_al  = (dsh >= 8'd27) ? {26'd0, |ms} : {sml_sh[26:1], sml_sh[0] | lost};
   assign bigx    = {1'b0, mb, 3'b000};
   assign sum_al  = eff_sub ? bigx - {1'b0, sml_al} : bigx + {1'b0, sml_al};

   // rounding of the subtract result
   logic        sub_up;
   logic [7:0]  sub_ef;
   logic [31:0] sub_res;
   assign sub_up  = sum_ff[2] & (sum_ff[1] | sum_ff[0] | sum_ff[3]);
   assign sub_ef  = sum_ff[26] ? sexp_ff : 8'd0;
   assign sub_res = (sexp_ff == bmmq_pkg::FLT_EXP_ALL_ONES) ? bmmq_pkg::FLT_INF_BITS :
                    {1'b0, sub_ef, sum_ff[25:3]} + 32'(sub_up);

   // one restoring division step
   logic        div_ge;
   logic [25:0] div_diff;
   assign div_ge   = rem_ff >= {2'b00, dm_ff};
   assign div_diff = div_ge ? rem_ff - {2'b00, dm_ff} : rem_ff;

   // quotient rounding to 53 bits
   logic [52:0]       q_m53;
   logic              q_g, q_st;
   logic signed [9:0] q_en;
   always_comb begin
      if (quo_ff[54]) begin
         q_m53 = quo_ff[54:2];
         q_g   = quo_ff[1];
         q_st  = quo_ff[0] | (rem_ff != 26'd0);
         q_en  = kexp_ff;
      end else begin
         q_m53 = quo_ff[53:1];
         q_g   = quo_ff[0];
         q_st  = rem_ff != 26'd0;
         q_en  = kexp_ff - 10'sd1;
      end
   end

   // norm * levels as (norm << s) - norm, rounded to 53 bits
   logic [4:0]  scale_sh, drop;
   logic [70:0] xs, xmask, xhalf, xlow;
   logic        x_top, x_up;
   assign scale_sh = wide_codes ? 5'd16 : 5'd8;
   assign xs       = ({17'd0, m54_ff} << scale_sh) - {17'd0, m54_ff};
   assign x_top    = wide_codes ? xs[68] : xs[60];
   assign drop     = x_top ? scale_sh : scale_sh - 5'd1;
   assign xmask    = (71'd1 << drop) - 71'd1;
   assign xhalf    = 71'd1 << (drop - 5'd1);
   assign xlow     = xs & xmask;
   assign x_up     = (xlow > xhalf) || (xlow == xhalf && xs[drop]);

   // fixed-point conversion with round half away
   logic signed [9:0] shs;
   logic [6:0]        sh;
   logic [70:0]       r_add;
   assign shs   = 10'sd52 - enorm_ff;
   assign sh    = shs[6:0];
   assign r_add = r_ff + (71'd1 << (sh - 7'd1));

   logic [15:0] levels;
   logic        can_load, is_last;
   assign levels   = wide_codes ? bmmq_pkg::LEVELS_WIDE : bmmq_pkg::LEVELS_NARROW;
   assign can_load = !rsp_valid_ff || rsp_ready;
   assign is_last  = (desc_ff.count == '0) ||
                     (idx_ff == desc_ff.count - bmmq_pkg::CNT_W'(1));
   assign pop      = (state_ff == ST_EMIT) && can_load && is_last;

   always_comb begin
      state_in     = state_ff;
      desc_in      = desc_ff;
      idx_in       = idx_ff;
      spread_in    = spread_ff;
      den_in       = den_ff;
      num_in       = num_ff;
      opa_in       = opa_ff;
      opb_in       = opb_ff;
      for_den_in   = for_den_ff;
      sum_in       = sum_ff;
      sexp_in      = sexp_ff;
      nm_in        = nm_ff;
      dm_in        = dm_ff;
      nexp_in      = nexp_ff;
      kexp_in      = kexp_ff;
      enorm_in     = enorm_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      m54_in       = m54_ff;
      r_in         = r_ff;
      code_in      = code_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         ST_IDLE: begin
            if (q_stat.valid) begin
               desc_in    = head;
               opa_in     = head.hi;
               opb_in     = head.lo;
               for_den_in = 1'b1;
               idx_in     = '0;
               state_in   = ST_SUB_ALIGN;
            end
         end
         ST_SUB_ALIGN: begin
            sum_in   = sum_al;
            sexp_in  = eb;
            state_in = ST_SUB_NORM;
         end
         ST_SUB_NORM: begin
            if (sum_ff[27]) begin
               sum_in   = {1'b0, sum_ff[27:2], sum_ff[1] | sum_ff[0]};
               sexp_in  = sexp_ff + 8'd1;
               state_in = ST_SUB_ROUND;
            end else if (!sum_ff[26] && sexp_ff > 8'd1) begin
               sum_in  = {sum_ff[26:0], 1'b0};
               sexp_in = sexp_ff - 8'd1;
            end else begin
               state_in = ST_SUB_ROUND;
            end
         end
         ST_SUB_ROUND: begin
            if (for_den_ff) begin
               den_in    = sub_res;
               spread_in = sub_res > bmmq_pkg::RANGE_EPS_BITS;
               if (desc_ff.count == '0) begin
                  code_in  = 16'd0;
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_READ;
               end
            end else begin
               num_in   = sub_res;
               state_in = ST_DIV_PREP;
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (!spread_ff) begin
               code_in  = 16'd0;
               state_in = ST_EMIT;
            end else begin
               if (bmmq_pkg::flt_finite(rd_data_ff)) opa_in = rd_data_ff;
               else opa_in = rd_data_ff[31] ? desc_ff.lo : desc_ff.hi;
               opb_in     = desc_ff.lo;
               for_den_in = 1'b0;
               state_in   = ST_SUB_ALIGN;
            end
         end
         ST_DIV_PREP: begin
            if (num_ff[30:0] == 31'd0) begin
               code_in  = 16'd0;
               state_in = ST_EMIT;
            end else if (den_ff[30:23] == bmmq_pkg::FLT_EXP_ALL_ONES) begin
               // inf / inf is NaN and codes full scale; finite / inf is zero
               code_in  = (num_ff[30:23] == bmmq_pkg::FLT_EXP_ALL_ONES) ? levels : 16'd0;
               state_in = ST_EMIT;
            end else begin
               nm_in    = {num_ff[30:23] != 8'd0, num_ff[22:0]};
               nexp_in  = (num_ff[30:23] == 8'd0) ? 10'sd1 : $signed({2'b00, num_ff[30:23]});
               dm_in    = {1'b1, den_ff[22:0]};
               state_in = ST_DIV_NORM;
            end
         end
         ST_DIV_NORM: begin
            if (nm_ff[23]) begin
               rem_in   = {2'b00, nm_ff};
               quo_in   = '0;
               step_in  = '0;
               kexp_in  = nexp_ff - $signed({2'b00, den_ff[30:23]});
               state_in = ST_DIV_STEP;
            end else begin
               nm_in   = {nm_ff[22:0], 1'b0};
               nexp_in = nexp_ff - 10'sd1;
            end
         end
         ST_DIV_STEP: begin
            quo_in  = {quo_ff[53:0], div_ge};
            rem_in  = {div_diff[24:0], 1'b0};
            step_in = step_ff + 6'd1;
            if (step_ff == 6'd54) state_in = ST_DIV_ROUND;
         end
         ST_DIV_ROUND: begin
            m54_in   = {1'b0, q_m53} + 54'(q_g & (q_st | q_m53[0]));
            enorm_in = q_en;
            if (q_en < bmmq_pkg::NORM_EXP_MIN) begin
               code_in  = 16'd0;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            r_in     = (xs & ~xmask) + (x_up ? (71'd1 << drop) : 71'd0);
            state_in = ST_CODE;
         end
         ST_CODE: begin
            code_in  = 16'(r_add >> sh);
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (can_load) begin
               rsp_in.code       = code_ff;
               rsp_in.code_valid = desc_ff.count != '0;
               rsp_in.block_min  = desc_ff.lo;
               rsp_in.block_max  = desc_ff.hi;
               rsp_in.block_last = is_last;
               rsp_in.overflowed = desc_ff.cut;
               rsp_valid_in      = 1'b1;
               if (is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + bmmq_pkg::CNT_W'(1);
                  state_in = ST_READ;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[{desc_ff.bank, idx_ff[IDX_W-1:0]}];
   end

   always_ff @(posedge clock) begin
      desc_ff    <= desc_in;
      idx_ff     <= idx_in;
      spread_ff  <= spread_in;
      den_ff     <= den_in;
      num_ff     <= num_in;
      opa_ff     <= opa_in;
      opb_ff     <= opb_in;
      for_den_ff <= for_den_in;
      sum_ff     <= sum_in;
      sexp_ff    <= sexp_in;
      nm_ff      <= nm_in;
      dm_ff      <= dm_in;
      nexp_ff    <= nexp_in;
      kexp_ff    <= kexp_in;
      enorm_ff   <= enorm_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      step_ff    <= step_in;
      m54_ff     <= m54_in;
      r_ff       <= r_in;
      code_ff    <= code_in;
      rsp_ff     <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- src/block_minmax_quantizer.sv -----
// Top level of the block min/max quantizer: config register, front end, queue, back end.
`timescale 1ns / 1ps

// Usage:
//   req_* (valid/ready): one float32 sample beat per item; has_sample = 0 with
//   block_end = 1 closes a block without adding a value. The front end takes one
//   beat per cycle and tracks min/max over finite values while it fills one of
//   two buffer banks; req_ready drops only while two closed blocks are pending.
//   rsp_* (valid/ready): one beat per buffered value, in input order, each with
//   block min/max; block_last marks the last beat, overflowed marks a block cut
//   at BLOCK_DEPTH values. An empty block gives one beat with code_valid = 0.
//   csr_write_enable/csr_write_data set wide_codes (16-bit codes, 65535 levels).
// Order: items run in sequence; a block's code beats start after its close.
//   A code beat skips the divide when the block range is not above 1e-8, else it
//   runs a 55-step bit-serial divide and one-bit normalize loops; a value equal
//   to the block min walks the subtract normalize loop one exponent step per
//   cycle. Each block first subtracts min from max for its range. Receiver
//   stalls add further delay.
// Reset (synchronous): clears fill state, min/max trackers, queue and output
//   valid; wide_codes returns to 0. Buffer contents are not cleared.
// Stall: while rsp_ready is low the back end holds in its emit step; the front
//   keeps taking beats until both banks hold closed blocks.

module block_minmax_quantizer #(
   parameter int BLOCK_DEPTH = bmmq_pkg::DEFAULT_BLOCK_DEPTH,
   localparam int IDX_W = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  bmmq_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output bmmq_pkg::rsp_type  rsp_data,
   input  logic               csr_write_enable,
   input  logic               csr_write_data
);

   logic wide_codes_ff, wide_codes_in;

   bmmq_pkg::qstat_type q_stat;
   bmmq_pkg::desc_type  push_desc, head;
   logic                push, pop;
   logic                wr_en;
   logic [IDX_W:0]      wr_addr;
   logic [31:0]         wr_data;

   // code width select; the user must write it only while the block is idle, the block does not enforce this
   assign wide_codes_in = csr_write_enable ? csr_write_data : wide_codes_ff;

   always_ff @(posedge clock) begin
      if (reset) wide_codes_ff <= 1'b0;
      else       wide_codes_ff <= wide_codes_in;
   end

   bmmq_front #(.BLOCK_DEPTH(BLOCK_DEPTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_ready (req_ready),
      .q_stat    (q_stat),
      .push      (push),
      .push_desc (push_desc),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data)
   );

   // one entry per buffer bank
   bmmq_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head      (head),
      .q_stat    (q_stat)
   );

   bmmq_back #(.BLOCK_DEPTH(BLOCK_DEPTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .wide_codes (wide_codes_ff),
      .q_stat     (q_stat),
      .head       (head),
      .pop        (pop),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

// ----- verif/block_minmax_quantizer_tb.sv -----
// Self-checking testbench for block_minmax_quantizer: directed table, then random blocks.
`timescale 1ns / 1ps

module block_minmax_quantizer_tb;

   localparam int DEPTH      = bmmq_pkg::DEFAULT_BLOCK_DEPTH;
   localparam int DRAIN_WAIT = 200;    // settle cycles after the last expected beat
   localparam int STALL_MAX  = 20000;  // cycles without any beat before giving up
   localparam int DIR_ROWS   = 22;

   // one row of the directed table; want is used only where typed is set
   typedef struct packed {
      bmmq_pkg::req_type beat;
      logic              typed;
      bmmq_pkg::rsp_type want;
   } dir_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   bmmq_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   bmmq_pkg::rsp_type rsp_data;
   logic              csr_write_enable = 1'b0;
   logic              csr_write_data = 1'b0;

   // predictor state
   logic [31:0]       pend_values[$];
   logic [31:0]       track_min;
   logic [31:0]       track_max;
   logic              seen_finite;
   logic              wide_mode;
   bmmq_pkg::rsp_type code_queue[$];

   int errors = 0;
   int send_idle = 0;   // percent of cycles the sender holds back
   int recv_idle = 0;   // percent of cycles the receiver stalls
   int quiet_cycles = 0;

   // directed beats: extremes, specials, empty and degenerate blocks
   dir_row_type dir_rows [DIR_ROWS] = '{
      // empty close right after reset
      '{'{32'h0000_0000, 1'b0, 1'b1}, 1'b1, '{16'd0, 1'b0, 32'd0, 32'd0, 1'b1, 1'b0}},
      // no value, no close: nothing happens
      '{'{32'hFFFF_FFFF, 1'b0, 1'b0}, 1'b0, '0},
      // lone NaN: no finite value, min = max = 0
      '{'{32'h7FC0_0000, 1'b1, 1'b1}, 1'b1, '{16'd0, 1'b1, 32'd0, 32'd0, 1'b1, 1'b0}},
      '{'{32'h3F80_0000, 1'b1, 1'b0}, 1'b0, '0},
      '{'{32'h4000_0000, 1'b1, 1'b0}, 1'b0, '0},
      '{'{32'h7F80_0000, 1'b1, 1'b0}, 1'b0, '0},
      '{'{32'hFF80_0000, 1'b1, 1'b0}, 1'b0, '0},
      '{'{32'h4040_0000, 1'b1, 1'b1}, 1'b0, '0},
      // full float range: range and v - min overflow
      '{'{32'h7F7F_FFFF, 1'b1, 1'b0}, 1'b0, '0},
      '{'{32'hFF7F_FFFF, 1'b1, 1'b0}, 1'b0, '0},
      '{'{32'h0000_0000, 1'b1, 1'b1}, 1'b0, '0},
      // signed zeros and subnormals
      '{'{32'h8000_0000, 1'b1, 1'b0}, 1'b0, '0},
      '{'{32'h0000_0000, 1'b1, 1'b0}, 1'b0, '0},
      '{'{32'h0000_0001, 1'b1, 1'b0}, 1'b0, '0},
      '{'{32'h807F_FFFF, 1'b1, 1'b1}, 1'b0, '0},
      // constant block codes to zero
      '{'{32'h40A0_0000, 1'b1, 1'b0}, 1'b0, '0},
      '{'{32'h40A0_0000, 1'b1, 1'b1}, 1'b1,
        '{16'd0, 1'b1, 32'h40A0_0000, 32'h40A0_0000, 1'b1, 1'b0}},
      // range of exactly 1e-8 is not above the threshold
      '{'{bmmq_pkg::RANGE_EPS_BITS, 1'b1, 1'b0}, 1'b0, '0},
      '{'{32'h0000_0000, 1'b1, 1'b0}, 1'b0, '0},
      '{'{32'hFFFF_FFFF, 1'b0, 1'b1}, 1'b0, '0},
      '{'{32'h1234_5678, 1'b1, 1'b0}, 1'b0, '0},
      '{'{32'hEDCB_A987, 1'b1, 1'b1}, 1'b0, '0}
   };

   block_minmax_quantizer i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // float helpers: single values are carried as bits, math done in real.
   // A double holds the exact difference or quotient closely enough that a
   // second rounding to single never differs from a direct one.
   // ---------------------------------------------------------------------
   function automatic logic is_inf_or_nan(input logic [31:0] b);
      return b[30:23] == bmmq_pkg::FLT_EXP_ALL_ONES;
   endfunction

   // finite single bits to real
   function automatic real single_to_real(input logic [31:0] b);
      real r;
      if (b[30:23] == 8'd0) begin
         r = real'(b[22:0]) * 2.0 ** (-149);
         if (b[31]) r = -r;
      end else begin
         r = $bitstoreal({b[31], 11'(b[30:23]) + 11'd896, b[22:0], 29'd0});
      end
      return r;
   endfunction

   // round a real to single, nearest even; overflow gives infinity
   function automatic logic [31:0] real_to_single(input real r);
      logic [63:0] d;
      logic [10:0] e;
      logic [52:0] sig;
      logic [52:0] kept;
      logic [30:0] mag;
      logic        guard;
      logic        sticky;
      int          sh;
      d   = $realtobits(r);
      e   = d[62:52];
      sig = {1'b1, d[51:0]};
      if (e == 11'd0) return {d[63], 31'd0};
      if (e > 11'd1150) return {d[63], bmmq_pkg::FLT_INF_BITS[30:0]};
      sh = (e >= 11'd897) ? 29 : 29 + (897 - int'(e));
      if (sh > 53) return {d[63], 31'd0};
      kept   = sig >> sh;
      guard  = sig[sh-1];
      sticky = |(sig & ((53'd1 << (sh - 1)) - 53'd1));
      if (e >= 11'd897) mag = {8'(e - 11'd896), kept[22:0]};
      else mag = 31'(kept);
      // carry out of the mantissa steps the exponent, up to infinity
      if (guard && (sticky || kept[0])) mag = mag + 31'd1;
      return {d[63], mag};
   endfunction

   function automatic logic [31:0] single_sub(input logic [31:0] a, input logic [31:0] b);
      return real_to_single(single_to_real(a) - single_to_real(b));
   endfunction

   // code of one buffered value against the block's min and max
   function automatic logic [15:0] quantize_value(input logic [31:0] vb,
                                                  input logic [31:0] lo,
                                                  input logic [31:0] hi,
                                                  input logic wide);
      real         levels;
      real         norm;
      real         scaled;
      logic [31:0] v;
      logic [31:0] num;
      logic [31:0] den;
      int          q;
      levels = wide ? 65535.0 : 255.0;
      v = !is_inf_or_nan(vb) ? vb : (vb[31] ? lo : hi);
      num = single_sub(v, lo);
      den = single_sub(hi, lo);
      // inf / inf is not a number: full scale
      if (is_inf_or_nan(num) && is_inf_or_nan(den))
         return wide ? bmmq_pkg::LEVELS_WIDE : bmmq_pkg::LEVELS_NARROW;
      if (is_inf_or_nan(num)) norm = 1.0;
      else if (is_inf_or_nan(den)) norm = 0.0;
      else norm = single_to_real(num) / single_to_real(den);
      if (norm < 0.0) norm = 0.0;
      if (norm > 1.0) norm = 1.0;
      scaled = norm * levels;
      q = int'($floor(scaled));
      if (scaled - real'(q) >= 0.5) q++;
      return 16'(q);
   endfunction

   function automatic void clear_tracking();
      pend_values.delete();
      track_min   = bmmq_pkg::FLT_MAX_BITS;
      track_max   = bmmq_pkg::FLT_LOWEST_BITS;
      seen_finite = 1'b0;
   endfunction

   // emit the expected code beats of the block now closing
   function automatic void close_block(input logic cut);
      logic [31:0]       lo;
      logic [31:0]       hi;
      logic [31:0]       range;
      logic              spread;
      bmmq_pkg::rsp_type r;
      lo = seen_finite ? track_min : 32'd0;
      hi = seen_finite ? track_max : 32'd0;
      range  = single_sub(hi, lo);
      spread = is_inf_or_nan(range) ||
               single_to_real(range) > single_to_real(bmmq_pkg::RANGE_EPS_BITS);
      if (pend_values.size() == 0) begin
         r = '{16'd0, 1'b0, lo, hi, 1'b1, cut};
         code_queue = {code_queue, r};
      end else begin
         foreach (pend_values[i]) begin
            r.code       = spread ? quantize_value(pend_values[i], lo, hi, wide_mode) : 16'd0;
            r.code_valid = 1'b1;
            r.block_min  = lo;
            r.block_max  = hi;
            r.block_last = (i == pend_values.size() - 1);
            r.overflowed = cut;
            code_queue = {code_queue, r};
         end
      end
      clear_tracking();
   endfunction

   // advance the block state by one accepted input beat
   function automatic void absorb_beat(input bmmq_pkg::req_type b);
      real v;
      if (b.has_sample && pend_values.size() < DEPTH) begin
         pend_values = {pend_values, b.sample};
         if (bmmq_pkg::flt_finite(b.sample)) begin
            v = single_to_real(b.sample);
            if (v < single_to_real(track_min)) track_min = b.sample;
            if (single_to_real(track_max) < v) track_max = b.sample;
            seen_finite = 1'b1;
         end
      end
      if (b.block_end) close_block(1'b0);
      else if (pend_values.size() >= DEPTH) close_block(1'b1);
   endfunction

   // ---------------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------------
   // Valid stays up between back-to-back beats; it drops only when the
   // sender decides to idle, so no step sees two writes to req_valid.
   task automatic send_beat(input bmmq_pkg::req_type b, input logic typed,
                            input bmmq_pkg::rsp_type want);
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      absorb_beat(b);
      // typed-in expectation replaces the predicted one for this row
      if (typed) code_queue[code_queue.size() - 1] = want;
   endtask

   task automatic finish_sending();
      req_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (code_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_wide(input logic w);
      csr_write_enable <= 1'b1;
      csr_write_data   <= w;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      wide_mode = w;
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_sample(input int base_exp, input logic tight,
                                               input logic [22:0] base_mant);
      logic [31:0] s;
      int          ex;
      case ($urandom_range(15))
         0: s = $urandom;
         1: begin
            case ($urandom_range(5))
               0: s = bmmq_pkg::FLT_INF_BITS;
               1: s = 32'hFF80_0000;
               2: s = {1'($urandom_range(1)), 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
               3: s = {1'($urandom_range(1)), 31'd0};
               4: s = $urandom_range(1) ? bmmq_pkg::FLT_MAX_BITS : bmmq_pkg::FLT_LOWEST_BITS;
               default: s = {1'($urandom_range(1)), 8'd0, 23'($urandom)};
            endcase
         end
         default: begin
            ex = base_exp + $urandom_range(4) - 2;
            if (tight) ex = base_exp;
            if (ex < 0) ex = 0;
            if (ex > 254) ex = 254;
            s = {tight ? 1'b0 : 1'($urandom_range(1)), 8'(ex),
                 tight ? base_mant ^ 23'($urandom_range(15)) : 23'($urandom)};
         end
      endcase
      return s;
   endfunction

   // random blocks with random content, sprinkled with no-op beats
   task automatic random_blocks(input int target);
      int                sent;
      int                len;
      int                kind;
      int                base_exp;
      logic              tight;
      logic              cut_run;
      logic              bare_close;
      logic [22:0]       base_mant;
      bmmq_pkg::req_type b;
      sent = 0;
      while (sent < target) begin
         kind       = $urandom_range(19);
         base_exp   = $urandom_range(254);
         base_mant  = 23'($urandom);
         tight      = ($urandom_range(4) == 0);
         cut_run    = 1'b0;
         bare_close = ($urandom_range(4) == 0);
         if (kind < 2) len = 0;
         else if (kind == 2) begin
            len = $urandom_range(60, DEPTH);
            cut_run = (len == DEPTH) && $urandom_range(1);
         end else len = $urandom_range(1, 6);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(9) == 0) begin
               b = '{32'($urandom), 1'b0, 1'b0};
               send_beat(b, 1'b0, '0);
            end
            b.sample     = pick_sample(base_exp, tight, base_mant);
            b.has_sample = 1'b1;
            // full buffer closes on its own when cut_run is set
            b.block_end  = (i == len - 1) && !cut_run && !bare_close;
            send_beat(b, 1'b0, '0);
            sent++;
         end
         if ((len == 0 || bare_close) && !cut_run) begin
            b = '{32'($urandom), 1'b0, 1'b1};
            send_beat(b, 1'b0, '0);
            sent++;
         end
      end
      finish_sending();
   endtask

   // receiver stalls at random per the current mode
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   // result check against the oldest expectation
   always @(posedge clock) begin
      bmmq_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (code_queue.size() == 0) begin
            $error("unexpected code beat %h", rsp_data);
            errors++;
         end else begin
            want = code_queue.pop_front();
            if (rsp_data.code !== want.code) begin
               $error("code: expected %h, got %h", want.code, rsp_data.code);
               errors++;
            end
            if (rsp_data.code_valid !== want.code_valid) begin
               $error("code_valid: expected %b, got %b", want.code_valid, rsp_data.code_valid);
               errors++;
            end
            if (rsp_data.block_min !== want.block_min) begin
               $error("block_min: expected %h, got %h", want.block_min, rsp_data.block_min);
               errors++;
            end
            if (rsp_data.block_max !== want.block_max) begin
               $error("block_max: expected %h, got %h", want.block_max, rsp_data.block_max);
               errors++;
            end
            if (rsp_data.block_last !== want.block_last) begin
               $error("block_last: expected %b, got %b", want.block_last, rsp_data.block_last);
               errors++;
            end
            if (rsp_data.overflowed !== want.overflowed) begin
               $error("overflowed: expected %b, got %b", want.overflowed, rsp_data.overflowed);
               errors++;
            end
         end
      end
   end

   // watchdog: too long without a beat on either side
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_MAX) begin
         $display("block_minmax_quantizer_tb: errors");
         $finish;
      end
   end

   initial begin
      clear_tracking();
      wide_mode = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table at both code widths, sender light / receiver heavy
      send_idle = 25;
      recv_idle = 67;
      for (int pass = 0; pass < 2; pass++) begin
         write_wide(1'(pass));
         foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
         finish_sending();
         wait_idle();
      end

      // random phases: sender light / receiver heavy, the reverse, then none
      write_wide(1'b1);
      random_blocks(85);
      wait_idle();

      send_idle = 67;
      recv_idle = 25;
      write_wide(1'b0);
      random_blocks(85);
      wait_idle();

      send_idle = 0;
      recv_idle = 0;
      write_wide(1'($urandom_range(1)));
      random_blocks(85);
      wait_idle();

      if (errors == 0) begin
         $display("block_minmax_quantizer_tb: clean");
      end else begin
         $display("block_minmax_quantizer_tb: errors");
      end
      $finish;
   end

endmodule
